// ===== src/acdm_pkg.sv =====
// Package for the adaptive color distance mask: types, codes and constants.
`default_nettype none
package acdm_pkg;
    localparam int unsigned GAIN_W = 17;
    localparam int unsigned SC_W = 26;
    localparam int unsigned DIST_W = 14;
    localparam logic [GAIN_W-1:0] GAIN_LO = 17'd10;
    localparam logic [GAIN_W-1:0] GAIN_HI = 17'd100000;
    localparam logic [SC_W-1:0] SC_MAX = '1;
    localparam logic [DIST_W-1:0] NEAR_INIT = '1;

    localparam logic [2:0] REG_TARGET_A = 3'd0;
    localparam logic [2:0] REG_TARGET_B = 3'd1;
    localparam logic [2:0] REG_DIST_LIMIT = 3'd2;
    localparam logic [2:0] REG_MIN_HARDSTOP = 3'd3;
    localparam logic [2:0] REG_SPREAD_TARGET = 3'd4;
    localparam logic [2:0] REG_GAIN_STEP = 3'd5;
    localparam logic [2:0] REG_GAIN_INITIAL = 3'd6;

    typedef enum logic [2:0] {
        t_ST_IDLE, t_ST_SQRT, t_ST_SCALE, t_ST_DIV, t_ST_UPD, t_ST_OUT
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;
        logic sqrt_step;
        logic sqrt_fin;
        logic mul;
        logic div;
        logic upd;
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic sqrt_done;
    } t_stat;

    function automatic logic [GAIN_W-1:0] clamp_gain(input logic signed [19:0] g);
        logic [GAIN_W-1:0] r;
        if (g < 20'sd10) r = GAIN_LO;
        else if (g > 20'sd100000) r = GAIN_HI;
        else r = g[GAIN_W-1:0];
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== src/adaptive_color_distance_mask.sv =====
// Top level of the adaptive color distance mask.
//  channel  | handshake              | payload
//  input    | i_valid / o_stall      | i_a_chan, i_b_chan, i_last_pixel
//  output   | o_valid / i_stall      | o_mask_value, o_frame_end, o_frame_suppressed, o_gain_next
//  config   | i_cfg_we               | i_cfg_idx, i_cfg_data
// One item is processed at a time, in the steps load, the bit-serial square root unit
// (thirteen bit steps and one rounding step), scale multiply, divide by ten,
// statistics update and result hand-off, which holds while the output stalls.
// Reset is synchronous and active low.
// A stalled result holds until taken; no new item is accepted meanwhile.
`default_nettype none
module adaptive_color_distance_mask
    import acdm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_a_chan,
    input  wire logic [7:0]  i_b_chan,
    input  wire logic        i_last_pixel,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_mask_value,
    output logic             o_frame_end,
    output logic             o_frame_suppressed,
    output logic [16:0]      o_gain_next,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [21:0] i_cfg_data
);
    t_cmd  cmd;
    t_stat stat;

    acdm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid),
        .i_out_stall(i_stall), .i_stat(stat), .o_stall(o_stall),
        .o_valid(o_valid), .o_cmd(cmd)
    );

    acdm_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_a_chan(i_a_chan), .i_b_chan(i_b_chan), .i_last_pixel(i_last_pixel),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_stat(stat), .o_mask_value(o_mask_value), .o_frame_end(o_frame_end),
        .o_frame_suppressed(o_frame_suppressed), .o_gain_next(o_gain_next)
    );
endmodule
`default_nettype wire

// ===== src/acdm_ctrl.sv =====
// Controller state machine for the color distance mask.
`default_nettype none
module acdm_ctrl
    import acdm_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire logic  i_out_stall,
    input  wire t_stat i_stat,
    output logic       o_stall,
    output logic       o_valid,
    output t_cmd       o_cmd
);
    t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= t_ST_IDLE;
        else r_state <= n_state;
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_stall = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            t_ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = t_ST_SQRT;
                end
            end
            t_ST_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_stat.sqrt_done) begin
                    o_cmd.sqrt_step = 1'b0;
                    o_cmd.sqrt_fin = 1'b1;
                    n_state = t_ST_SCALE;
                end
            end
            t_ST_SCALE: begin
                o_cmd.mul = 1'b1;
                n_state = t_ST_DIV;
            end
            t_ST_DIV: begin
                o_cmd.div = 1'b1;
                n_state = t_ST_UPD;
            end
            t_ST_UPD: begin
                o_cmd.upd = 1'b1;
                n_state = t_ST_OUT;
            end
            t_ST_OUT: begin
                o_valid = 1'b1;
                if (!i_out_stall) n_state = t_ST_IDLE;
            end
            default: n_state = t_ST_IDLE;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == t_ST_UPD) |=> (r_state == t_ST_OUT))
        else $error("update not followed by output");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken while result pending");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == t_ST_OUT && i_out_stall) |=> (r_state == t_ST_OUT))
        else $error("stalled result dropped");
endmodule
`default_nettype wire

// ===== src/acdm_dp.sv =====
// Datapath: distance, square root, scaling, frame statistics and gain control.
`default_nettype none
module acdm_dp
    import acdm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    input  wire logic [7:0]  i_a_chan,
    input  wire logic [7:0]  i_b_chan,
    input  wire logic        i_last_pixel,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [21:0] i_cfg_data,
    output t_stat            o_stat,
    output logic [7:0]       o_mask_value,
    output logic             o_frame_end,
    output logic             o_frame_suppressed,
    output logic [16:0]      o_gain_next
);
    logic [11:0] r_tgt_a, r_tgt_b;
    logic [12:0] r_lim, r_hard;
    logic [21:0] r_spread;
    logic [9:0]  r_step;
    logic [GAIN_W-1:0] r_gain;
    logic [SC_W-1:0] r_pmin, r_fmin, r_fmax;
    logic [DIST_W-1:0] r_near;

    logic [14:0] r_x;      // square root remainder
    logic [25:0] r_sq;
    logic [12:0] r_root;
    logic [3:0]  r_cnt;
    logic [DIST_W-1:0] r_dist;
    logic [30:0] r_prod;
    logic [SC_W-1:0] r_scaled;
    logic r_last;

    logic signed [12:0] da, db;
    logic [25:0] sq;
    logic [16:0] trial;
    logic [16:0] rr;
    logic [30:0] q;
    logic [34:0] recip;
    logic [30:0] rem;
    logic [27:0] quo;
    logic signed [SC_W:0] diff;
    logic [11:0] dcl;
    logic [8:0]  rnd;
    logic [SC_W:0] spr;
    logic [26:0] want;
    logic signed [19:0] gnew;
    logic in_range;
    logic [DIST_W-1:0] near_upd;
    logic [SC_W-1:0] fmin_upd, fmax_upd;
    logic suppress;

    assign da = $signed({1'b0, i_a_chan, 4'b0}) - $signed({1'b0, r_tgt_a});
    assign db = $signed({1'b0, i_b_chan, 4'b0}) - $signed({1'b0, r_tgt_b});
    assign sq = 26'(27'(da * da) + 27'(db * db));
    // One restoring square root bit per cycle, two remainder bits in.
    assign trial = {r_x, r_sq[25:24]};
    assign rr = {2'd0, r_root, 2'b01};
    assign o_stat.sqrt_done = (r_cnt == 4'd13);

    // Divide by ten with a reciprocal multiply and a correction.
    assign q = r_prod + 31'd5;
    assign recip = 35'((64'(q) * 64'd3435973837) >> 35);
    assign rem = q - 31'(recip) * 31'd10;
    assign quo = (rem >= 31'd10) ? 28'(recip) + 28'd1 : 28'(recip);

    assign in_range = (r_dist < {1'b0, r_lim});
    assign diff = $signed({1'b0, r_scaled}) - $signed({1'b0, r_pmin});
    assign dcl = (diff < 0) ? 12'd0 : (diff > 27'sd4080) ? 12'd4080 : diff[11:0];
    assign rnd = 9'((13'(dcl) + 13'd8) >> 4);

    // Frame statistics including the current pixel, used on the last pixel.
    assign near_upd = (in_range && (r_dist < r_near)) ? r_dist : r_near;
    assign fmin_upd = (in_range && (r_scaled < r_fmin)) ? r_scaled : r_fmin;
    assign fmax_upd = (in_range && (r_scaled > r_fmax)) ? r_scaled : r_fmax;
    assign suppress = (near_upd > {1'b0, r_hard});
    assign spr = {1'b0, fmax_upd} - {1'b0, fmin_upd};
    assign want = {1'b0, r_spread, 4'b0};

    always_comb begin
        gnew = $signed({3'b0, r_gain});
        if ($signed(spr) < $signed({1'b0, want[25:0]}) || want[26]) gnew = gnew + $signed({10'b0, r_step});
        else if ($signed(spr) > $signed({1'b0, want[25:0]})) gnew = gnew - $signed({10'b0, r_step});
    end

    // Configuration registers, gain preload, square root counter and frame statistics.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt_a <= 12'd1890;
            r_tgt_b <= 12'd2835;
            r_lim <= 13'd5920;
            r_hard <= 13'd800;
            r_spread <= 22'd1000;
            r_step <= 10'd1;
            r_gain <= 17'd100;
            r_pmin <= '0;
            r_fmin <= SC_MAX;
            r_fmax <= '0;
            r_near <= NEAR_INIT;
            r_cnt <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TARGET_A: r_tgt_a <= i_cfg_data[11:0];
                    REG_TARGET_B: r_tgt_b <= i_cfg_data[11:0];
                    REG_DIST_LIMIT: r_lim <= i_cfg_data[12:0];
                    REG_MIN_HARDSTOP: r_hard <= i_cfg_data[12:0];
                    REG_SPREAD_TARGET: r_spread <= i_cfg_data;
                    REG_GAIN_STEP: r_step <= i_cfg_data[9:0];
                    REG_GAIN_INITIAL: r_gain <= clamp_gain($signed({3'b0, i_cfg_data[16:0]}));
                    default: ;
                endcase
            end
            if (i_cmd.load) r_cnt <= '0;
            else if (i_cmd.sqrt_step) r_cnt <= r_cnt + 4'd1;
            if (i_cmd.upd) begin
                if (in_range) begin
                    if (r_dist < r_near) r_near <= r_dist;
                    if (r_scaled < r_fmin) r_fmin <= r_scaled;
                    if (r_scaled > r_fmax) r_fmax <= r_scaled;
                end
            end
            if (i_cmd.upd && r_last) begin
                r_fmin <= SC_MAX;
                r_fmax <= '0;
                r_near <= NEAR_INIT;
                if (!suppress) begin
                    r_pmin <= fmin_upd;
                    r_gain <= clamp_gain(gnew);
                end
            end
        end
    end

    // Square root, scale and result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sq <= sq;
            r_x <= '0;
            r_root <= '0;
            r_last <= i_last_pixel;
        end
        if (i_cmd.sqrt_step) begin
            r_sq <= {r_sq[23:0], 2'b0};
            if (trial >= rr) begin
                r_x <= 15'(trial - rr);
                r_root <= {r_root[11:0], 1'b1};
            end else begin
                r_x <= 15'(trial);
                r_root <= {r_root[11:0], 1'b0};
            end
        end
        // Round to nearest: remainder above root means round up.
        if (i_cmd.sqrt_fin) r_dist <= (r_x > {2'd0, r_root}) ? 14'(r_root) + 14'd1 : 14'(r_root);
        if (i_cmd.mul) r_prod <= 31'(r_dist * r_gain);
        if (i_cmd.div) r_scaled <= (quo > 28'(SC_MAX)) ? SC_MAX : quo[SC_W-1:0];
        if (i_cmd.upd) begin
            o_mask_value <= in_range ? 8'(9'd255 - rnd) : 8'd0;
            o_frame_end <= r_last;
            o_frame_suppressed <= r_last && suppress;
            o_gain_next <= r_last ? (suppress ? r_gain : clamp_gain(gnew)) : 17'd0;
        end
    end
endmodule
`default_nettype wire

// ===== verif/acdm_checker.sv =====
// Checker for the adaptive color distance mask: predicts each result and compares it.
`timescale 1ns / 1ps
`default_nettype none
module acdm_checker
    import acdm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        i_stall_in,
    input  wire logic [7:0]  i_a_chan,
    input  wire logic [7:0]  i_b_chan,
    input  wire logic        i_last_pixel,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [7:0]  i_mask_value,
    input  wire logic        i_frame_end,
    input  wire logic        i_frame_suppressed,
    input  wire logic [16:0] i_gain_next,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [21:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);
    typedef struct packed {
        logic [7:0]  mask;
        logic        fend;
        logic        supp;
        logic [16:0] gain;
    } t_pixel_result;

    t_pixel_result expected_q[$];

    logic [11:0] tgt_a, tgt_b;
    logic [12:0] dist_lim, hardstop;
    logic [21:0] spread_tgt;
    logic [9:0]  step;
    logic [16:0] cur_gain;
    logic [25:0] last_min, fmin, fmax;
    logic [13:0] nearest;

    assign o_pending = expected_q.size();

    // Integer square root rounded to nearest.
    function automatic logic [31:0] root_nearest(input logic [31:0] s);
        logic [31:0] r, b, x;
        r = 0;
        b = 32'h4000_0000;
        x = s;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        if (s - r * r > r) r = r + 1;
        return r;
    endfunction

    function automatic logic [16:0] gain_limit(input longint g);
        if (g < 10) return 17'd10;
        if (g > 100000) return 17'd100000;
        return g[16:0];
    endfunction

    // Advance the predicted state by one pixel and return its result.
    function automatic t_pixel_result predict_pixel(input logic [7:0] a, input logic [7:0] b,
                                                    input logic lastp);
        t_pixel_result res;
        longint da, db, sc, diff, spread, want, g;
        logic [31:0] pix_dist;
        da = longint'({a, 4'b0}) - longint'(tgt_a);
        db = longint'({b, 4'b0}) - longint'(tgt_b);
        pix_dist = root_nearest(32'(da * da + db * db));
        res = '0;
        if (pix_dist < dist_lim) begin
            if (pix_dist < nearest) nearest = pix_dist[13:0];
            sc = (longint'(pix_dist) * cur_gain + 5) / 10;
            if (sc > 64'h3FF_FFFF) sc = 64'h3FF_FFFF;
            if (sc < fmin) fmin = sc[25:0];
            if (sc > fmax) fmax = sc[25:0];
            diff = sc - longint'(last_min);
            if (diff < 0) diff = 0;
            if (diff > 4080) diff = 4080;
            res.mask = 8'(255 - ((diff + 8) >> 4));
        end
        res.fend = lastp;
        if (lastp) begin
            res.supp = nearest > hardstop;
            if (!res.supp) begin
                spread = longint'(fmax) - longint'(fmin);
                want = longint'(spread_tgt) << 4;
                g = cur_gain;
                last_min = fmin;
                if (spread < want) g = g + step;
                if (spread > want) g = g - step;
                cur_gain = gain_limit(g);
            end
            res.gain = cur_gain;
            fmin = '1;
            fmax = '0;
            nearest = '1;
        end
        return res;
    endfunction

    // Track configuration, predict on input items, compare on result items.
    always @(posedge i_clk) begin
        t_pixel_result got, want;
        if (!i_rst_n) begin
            tgt_a <= 12'd1890;
            tgt_b <= 12'd2835;
            dist_lim <= 13'd5920;
            hardstop <= 13'd800;
            spread_tgt <= 22'd1000;
            step <= 10'd1;
            cur_gain <= 17'd100;
            last_min <= '0;
            fmin <= '1;
            fmax <= '0;
            nearest <= '1;
            o_fail_count <= 0;
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TARGET_A: tgt_a <= i_cfg_data[11:0];
                    REG_TARGET_B: tgt_b <= i_cfg_data[11:0];
                    REG_DIST_LIMIT: dist_lim <= i_cfg_data[12:0];
                    REG_MIN_HARDSTOP: hardstop <= i_cfg_data[12:0];
                    REG_SPREAD_TARGET: spread_tgt <= i_cfg_data;
                    REG_GAIN_STEP: step <= i_cfg_data[9:0];
                    REG_GAIN_INITIAL: cur_gain <= gain_limit(longint'(i_cfg_data[16:0]));
                    default: ;
                endcase
            end
            if (i_valid && !i_stall_in)
                expected_q.push_back(predict_pixel(i_a_chan, i_b_chan, i_last_pixel));
            if (i_out_valid && !i_out_stall) begin
                got = '{i_mask_value, i_frame_end, i_frame_suppressed, i_gain_next};
                if (expected_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("Unexpected result: mask %0d end %0d supp %0d gain %0d",
                                 got.mask, got.fend, got.supp, got.gain);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (got != want) begin
                        if (o_fail_count < 10)
                            $display("Result differs: expected mask %0d end %0d supp %0d gain %0d, got mask %0d end %0d supp %0d gain %0d",
                                     want.mask, want.fend, want.supp, want.gain,
                                     got.mask, got.fend, got.supp, got.gain);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// Testbench top for the adaptive color distance mask: stimulus, configuration and verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import acdm_pkg::*;

    // Register index that no register uses.
    localparam logic [2:0] REG_NONE = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  a_chan = '0;
    logic [7:0]  b_chan = '0;
    logic        last_pixel = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  mask_value;
    logic        frame_end;
    logic        frame_suppressed;
    logic [16:0] gain_next;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_idx = '0;
    logic [21:0] cfg_data = '0;
    int          fail_count;
    int          pending;
    int          stall_left = 0;
    bit          draining = 1'b0;

    always #10 clk = ~clk;

    adaptive_color_distance_mask DUT (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_a_chan(a_chan), .i_b_chan(b_chan), .i_last_pixel(last_pixel),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_mask_value(mask_value), .o_frame_end(frame_end),
        .o_frame_suppressed(frame_suppressed), .o_gain_next(gain_next),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    acdm_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .i_stall_in(in_stall),
        .i_a_chan(a_chan), .i_b_chan(b_chan), .i_last_pixel(last_pixel),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_mask_value(mask_value), .i_frame_end(frame_end),
        .i_frame_suppressed(frame_suppressed), .i_gain_next(gain_next),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver stall: after each result taken, a random run of stalled cycles, often none; none while draining.
    always @(posedge clk) begin
        int hold;
        if (draining) begin
            out_stall <= 1'b0;
        end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else if (stall_left == 1) begin
            stall_left <= 0;
            out_stall <= 1'b0;
        end else if (out_valid && !out_stall) begin
            hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            out_stall <= (hold != 0);
            stall_left <= hold;
        end
    end

    // Send one pixel and wait until it is accepted; valid stays up for a following item.
    task automatic send_pixel(input logic [7:0] a, input logic [7:0] b, input logic lastp);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        a_chan <= a;
        b_chan <= b;
        last_pixel <= lastp;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Wait until every expected result has come and the block is quiet.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [21:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // A frame of pixels, most of them near a random center.
    task automatic send_frame(input int len);
        logic [7:0] ca, cb;
        ca = 8'($urandom);
        cb = 8'($urandom);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_pixel(8'($urandom), 8'($urandom), i == len - 1);
            else
                send_pixel(ca + 8'($urandom_range(0, 6)) - 8'd3,
                           cb + 8'($urandom_range(0, 6)) - 8'd3, i == len - 1);
        end
    endtask

    // Pick a random setting of every register, often extreme.
    task automatic random_setting();
        write_reg(REG_TARGET_A, 22'($urandom_range(0, 4095)));
        write_reg(REG_TARGET_B, 22'($urandom_range(0, 4095)));
        write_reg(REG_DIST_LIMIT,
                  22'(($urandom_range(0, 3) == 0) ? 5920 : $urandom_range(0, 5920)));
        write_reg(REG_MIN_HARDSTOP,
                  22'(($urandom_range(0, 2) == 0) ? 5920 : $urandom_range(0, 5920)));
        write_reg(REG_SPREAD_TARGET, ($urandom_range(0, 5) == 0) ? 22'h3FFFFF
                                                                 : 22'($urandom_range(0, 2000)));
        write_reg(REG_GAIN_STEP, 22'($urandom_range(0, 1000)));
        write_reg(REG_GAIN_INITIAL,
                  22'(($urandom_range(0, 4) == 0) ? 100000 : $urandom_range(10, 2000)));
    endtask

    initial begin
        int sent;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // Extremes under reset values.
        send_pixel(8'd0, 8'd0, 1'b0);
        send_pixel(8'd255, 8'd255, 1'b0);
        send_pixel(8'd118, 8'd177, 1'b0);
        send_pixel(8'd120, 8'd175, 1'b1);
        // Frame of a single pixel, within the limit under reset values.
        send_pixel(8'd0, 8'd0, 1'b1);
        settle();
        // Gain at top with large step, clamping high.
        write_reg(REG_GAIN_INITIAL, 22'd100000);
        write_reg(REG_GAIN_STEP, 22'd1000);
        write_reg(REG_SPREAD_TARGET, 22'h3FFFFF);
        write_reg(REG_MIN_HARDSTOP, 22'd5920);
        send_pixel(8'd0, 8'd0, 1'b0);
        send_pixel(8'd255, 8'd0, 1'b1);
        settle();
        // Spread target zero pushes the gain down to its floor.
        write_reg(REG_GAIN_INITIAL, 22'd10);
        write_reg(REG_SPREAD_TARGET, 22'd0);
        write_reg(REG_TARGET_A, 22'd0);
        write_reg(REG_TARGET_B, 22'd4095);
        send_pixel(8'd0, 8'd255, 1'b0);
        send_pixel(8'd10, 8'd250, 1'b1);
        settle();
        write_reg(REG_GAIN_INITIAL, 22'd0);
        write_reg(REG_DIST_LIMIT, 22'd0);
        write_reg(REG_MIN_HARDSTOP, 22'd0);
        write_reg(REG_NONE, 22'h3FFFFF);
        send_pixel(8'd0, 8'd255, 1'b1);
        settle();
        write_reg(REG_DIST_LIMIT, 22'd5920);
        write_reg(REG_GAIN_STEP, 22'd0);
        send_pixel(8'd0, 8'd255, 1'b0);
        send_pixel(8'd0, 8'd255, 1'b1);
        settle();
        // Random frames, settings changed between phases.
        sent = 0;
        while (sent < 1000) begin
            if ($urandom_range(0, 4) == 0) begin
                settle();
                random_setting();
            end
            if ($urandom_range(0, 9) == 0) begin
                send_pixel(8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
                sent++;
            end else begin
                int len;
                len = $urandom_range(1, 24);
                send_frame(len);
                sent += len;
            end
        end
        draining = 1'b1;
        settle();
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #100ms;
        $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire
